>>> rtl/dfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_pkg - delimited frame receiver shared definitions
// Event codes, delimiter bytes, store capacities and the result record.
// ----------------------------------------------------------------------------
package dfr_pkg;

	localparam int unsigned CMD_CAPACITY  = 64;
	localparam int unsigned TUNE_CAPACITY = 32;
	localparam int unsigned CMD_LEN_W     = $clog2(CMD_CAPACITY);
	localparam int unsigned TUNE_LEN_W    = $clog2(TUNE_CAPACITY);

	localparam logic [7:0] CMD_OPEN   = 8'h28; // '('
	localparam logic [7:0] CMD_CLOSE  = 8'h29; // ')'
	localparam logic [7:0] TUNE_OPEN  = 8'h3C; // '<'
	localparam logic [7:0] TUNE_CLOSE = 8'h3E; // '>'
	localparam logic [7:0] FWD_START  = 8'hEE;

	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_TUNE = 1'b1;

	typedef enum logic [2:0] {
		EV_IGNORED     = 3'd0,
		EV_STARTED     = 3'd1,
		EV_STORED      = 3'd2,
		EV_DROPPED     = 3'd3,
		EV_COMPLETE    = 3'd4,
		EV_FORWARDED   = 3'd5,
		EV_FWD_ENTERED = 3'd6
	} event_t;

	typedef struct packed {
		logic [2:0] ev;
		logic       kind;
		logic [5:0] pos;
		logic [7:0] data;
		logic [5:0] len;
	} res_t;

endpackage

>>> rtl/dfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_parser - frame mode tracker
// Holds the receive mode and both frame lengths, and decodes one byte per
// cycle into a result record; its state moves on only while advance is high.
// ----------------------------------------------------------------------------
module dfr_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic [7:0]    rx_byte,
	output dfr_pkg::res_t res
);
	import dfr_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_CMD  = 2'd1,
		MODE_TUNE = 2'd2,
		MODE_FWD  = 2'd3
	} mode_t;

	mode_t                 mode_q, mode_d;
	logic [CMD_LEN_W-1:0]  cmd_len_q, cmd_len_d;
	logic [TUNE_LEN_W-1:0] tune_len_q, tune_len_d;
	logic                  cmd_full, tune_full;

	assign cmd_full  = (cmd_len_q == CMD_LEN_W'(CMD_CAPACITY - 1));
	assign tune_full = (tune_len_q == TUNE_LEN_W'(TUNE_CAPACITY - 1));

	always_comb begin
		res        = '0;
		mode_d     = mode_q;
		cmd_len_d  = cmd_len_q;
		tune_len_d = tune_len_q;
		// start bytes win in every mode
		if (rx_byte == CMD_OPEN) begin
			mode_d    = MODE_CMD;
			cmd_len_d = '0;
			res.ev    = EV_STARTED;
			res.kind  = KIND_CMD;
		end else if (rx_byte == TUNE_OPEN) begin
			mode_d     = MODE_TUNE;
			tune_len_d = '0;
			res.ev     = EV_STARTED;
			res.kind   = KIND_TUNE;
		end else if (rx_byte == FWD_START) begin
			mode_d = MODE_FWD;
			res.ev = EV_FWD_ENTERED;
		end else begin
			case (mode_q)
				MODE_CMD: begin
					res.kind = KIND_CMD;
					if (rx_byte == CMD_CLOSE) begin
						mode_d  = MODE_IDLE;
						res.ev  = EV_COMPLETE;
						res.len = 6'(cmd_len_q);
					end else if (cmd_full) begin
						res.ev   = EV_DROPPED;
						res.data = rx_byte;
						res.len  = 6'(cmd_len_q);
					end else begin
						cmd_len_d = cmd_len_q + 1'b1;
						res.ev    = EV_STORED;
						res.pos   = 6'(cmd_len_q);
						res.data  = rx_byte;
						res.len   = 6'(cmd_len_d);
					end
				end
				MODE_TUNE: begin
					res.kind = KIND_TUNE;
					if (rx_byte == TUNE_CLOSE) begin
						mode_d  = MODE_IDLE;
						res.ev  = EV_COMPLETE;
						res.len = 6'(tune_len_q);
					end else if (tune_full) begin
						res.ev   = EV_DROPPED;
						res.data = rx_byte;
						res.len  = 6'(tune_len_q);
					end else begin
						tune_len_d = tune_len_q + 1'b1;
						res.ev     = EV_STORED;
						res.pos    = 6'(tune_len_q);
						res.data   = rx_byte;
						res.len    = 6'(tune_len_d);
					end
				end
				MODE_FWD: begin
					res.ev   = EV_FORWARDED;
					res.data = rx_byte;
				end
				default: begin
					res.ev = EV_IGNORED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			cmd_len_q  <= '0;
			tune_len_q <= '0;
		end else if (advance) begin
			mode_q     <= mode_d;
			cmd_len_q  <= cmd_len_d;
			tune_len_q <= tune_len_d;
		end
	end

endmodule

>>> rtl/dfr_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_out_stage - result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module dfr_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load_valid,
	output logic          load_ready,
	input  dfr_pkg::res_t load_res,
	output logic          res_valid,
	input  logic          res_ready,
	output dfr_pkg::res_t res_q
);
	import dfr_pkg::*;

	logic valid_q;

	assign load_ready = !valid_q || res_ready;
	assign res_valid  = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			res_q <= load_res;
		end
	end

endmodule

>>> rtl/delimited_frame_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_frame_receiver_top - delimited serial frame receiver
// Sorts received bytes into command and tuning frames and a forward stream.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one result beat. A byte is registered on
// acceptance, decoded against the mode and frame lengths from that register,
// and its result is registered into the output stage once that stage has room,
// where it waits on the result ports until taken; one byte per cycle is sustained
// as long as res_ready stays high. rx_ready depends combinationally on res_ready.
// Frame payload is delivered on the result channel as store events carrying
// the byte and its position; the block keeps only the lengths.
module delimited_frame_receiver_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [2:0] event_res,
	output logic       frame_kind,
	output logic [5:0] position,
	output logic [7:0] data_byte,
	output logic [5:0] frame_length
);
	import dfr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       load_ready;
	logic       advance;
	res_t       dec_res;
	res_t       res_q;

	assign advance  = valid_s1 && load_ready;
	assign rx_ready = !valid_s1 || load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	dfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (byte_s1),
		.res     (dec_res)
	);

	dfr_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (load_ready),
		.load_res   (dec_res),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_q      (res_q)
	);

	assign event_res    = res_q.ev;
	assign frame_kind   = res_q.kind;
	assign position     = res_q.pos;
	assign data_byte    = res_q.data;
	assign frame_length = res_q.len;

endmodule

>>> rtl/dfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_checker - port-level checks for the frame receiver
// Watches the result channel for stall behaviour and field consistency.
// ----------------------------------------------------------------------------
module dfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] event_res,
	input logic       frame_kind,
	input logic [5:0] position,
	input logic [7:0] data_byte,
	input logic [5:0] frame_length
);
	import dfr_pkg::*;

	// hold a stalled result beat
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(event_res)
			&& $stable(data_byte) && $stable(frame_length) && $stable(position))
		else $error("result beat changed while stalled");

	a_pos_only_stored: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res != EV_STORED |-> position == 6'd0)
		else $error("position set on a non-store event");

	a_nonframe_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (event_res == EV_IGNORED || event_res == EV_FORWARDED
			|| event_res == EV_FWD_ENTERED) |-> !frame_kind && frame_length == 6'd0)
		else $error("frame fields set outside a frame");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res == EV_STARTED |-> frame_length == 6'd0 && data_byte == 8'd0)
		else $error("frame start carries data");

	a_store_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res == EV_STORED |-> frame_length == position + 6'd1)
		else $error("stored length does not follow position");

endmodule

bind delimited_frame_receiver_top dfr_checker u_dfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res_valid),
	.res_ready    (res_ready),
	.event_res    (event_res),
	.frame_kind   (frame_kind),
	.position     (position),
	.data_byte    (data_byte),
	.frame_length (frame_length)
);

>>> tb/frame_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_event_checker - result checker for the delimited frame receiver
// Watches both channels, predicts the event for every accepted byte and
// compares each accepted result beat with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module frame_event_checker
	import dfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	input  logic       rx_ready,
	input  logic [7:0] rx_byte,
	input  logic       res_valid,
	input  logic       res_ready,
	input  logic [2:0] event_res,
	input  logic       frame_kind,
	input  logic [5:0] position,
	input  logic [7:0] data_byte,
	input  logic [5:0] frame_length,
	output int         fail_count,
	output int         pending_results
);

	typedef enum logic [1:0] {
		RX_IDLE,
		RX_CMD_FRAME,
		RX_TUNE_FRAME,
		RX_FORWARD
	} rx_mode_t;

	rx_mode_t              rx_mode;
	logic [CMD_LEN_W-1:0]  cmd_len;
	logic [TUNE_LEN_W-1:0] tune_len;
	res_t                  expected_events[$];
	int                    issued_beats;
	int                    retired_beats;

	assign pending_results = issued_beats - retired_beats;

	// Work out the event for one received byte and advance the mode and lengths.
	function automatic res_t next_frame_event(input logic [7:0] b);
		res_t r;
		r = '0;
		if (b == CMD_OPEN) begin
			rx_mode = RX_CMD_FRAME;
			cmd_len = '0;
			r.ev    = EV_STARTED;
			r.kind  = KIND_CMD;
		end else if (b == TUNE_OPEN) begin
			rx_mode  = RX_TUNE_FRAME;
			tune_len = '0;
			r.ev     = EV_STARTED;
			r.kind   = KIND_TUNE;
		end else if (b == FWD_START) begin
			rx_mode = RX_FORWARD;
			r.ev    = EV_FWD_ENTERED;
		end else if (rx_mode == RX_CMD_FRAME) begin
			r.kind = KIND_CMD;
			if (b == CMD_CLOSE) begin
				rx_mode = RX_IDLE;
				r.ev    = EV_COMPLETE;
				r.len   = 6'(cmd_len);
			end else if (int'(cmd_len) < CMD_CAPACITY - 1) begin
				r.ev    = EV_STORED;
				r.pos   = 6'(cmd_len);
				r.data  = b;
				cmd_len = cmd_len + 1'b1;
				r.len   = 6'(cmd_len);
			end else begin
				r.ev   = EV_DROPPED;
				r.data = b;
				r.len  = 6'(cmd_len);
			end
		end else if (rx_mode == RX_TUNE_FRAME) begin
			r.kind = KIND_TUNE;
			if (b == TUNE_CLOSE) begin
				rx_mode = RX_IDLE;
				r.ev    = EV_COMPLETE;
				r.len   = 6'(tune_len);
			end else if (int'(tune_len) < TUNE_CAPACITY - 1) begin
				r.ev     = EV_STORED;
				r.pos    = 6'(tune_len);
				r.data   = b;
				tune_len = tune_len + 1'b1;
				r.len    = 6'(tune_len);
			end else begin
				r.ev   = EV_DROPPED;
				r.data = b;
				r.len  = 6'(tune_len);
			end
		end else if (rx_mode == RX_FORWARD) begin
			r.ev   = EV_FORWARDED;
			r.data = b;
		end else begin
			r.ev = EV_IGNORED;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t frame_event_checker: %s expected %0d actual %0d",
				$time, name, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t exp_ev;
		if (!arst_n) begin
			rx_mode       = RX_IDLE;
			cmd_len       = '0;
			tune_len      = '0;
			expected_events.delete();
			issued_beats  = 0;
			retired_beats = 0;
			fail_count    = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_events.size() == 0) begin
					$display("%0t frame_event_checker: result beat with nothing expected, event %0d",
						$time, event_res);
					fail_count++;
				end else begin
					exp_ev = expected_events.pop_front();
					retired_beats++;
					check_field("event_res", int'(exp_ev.ev), int'(event_res));
					check_field("frame_kind", int'(exp_ev.kind), int'(frame_kind));
					check_field("position", int'(exp_ev.pos), int'(position));
					check_field("data_byte", int'(exp_ev.data), int'(data_byte));
					check_field("frame_length", int'(exp_ev.len), int'(frame_length));
				end
			end
			if (rx_valid && rx_ready) begin
				expected_events.push_back(next_frame_event(rx_byte));
				issued_beats++;
			end
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - delimited frame receiver testbench
// Feeds directed delimiter cases, then random frames, forward runs and noise
// in bursts while the result side stalls; the checker scores every beat.
// ----------------------------------------------------------------------------
module tb_top;
	import dfr_pkg::*;

	localparam int RANDOM_ITEMS   = 750;
	localparam int WATCHDOG_LIMIT = 4000;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       rx_valid  = 1'b0;
	logic [7:0] rx_byte   = 8'h00;
	logic       res_ready = 1'b0;
	logic       rx_ready;
	logic       res_valid;
	logic [2:0] event_res;
	logic       frame_kind;
	logic [5:0] position;
	logic [7:0] data_byte;
	logic [5:0] frame_length;
	int         fail_count;
	int         pending_results;

	int         burst_left   = 0;
	int         framed_items = 0;
	int         idle_cycles  = 0;
	int         stall_cycle  = 0;
	int         stall_mode   = 0;

	delimited_frame_receiver_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.event_res    (event_res),
		.frame_kind   (frame_kind),
		.position     (position),
		.data_byte    (data_byte),
		.frame_length (frame_length)
	);

	frame_event_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_valid        (rx_valid),
		.rx_ready        (rx_ready),
		.rx_byte         (rx_byte),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.event_res       (event_res),
		.frame_kind      (frame_kind),
		.position        (position),
		.data_byte       (data_byte),
		.frame_length    (frame_length),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
	end

	// Result side: drive res_ready from one of four stall patterns, chosen at random.
	always @(negedge clk) begin
		stall_cycle++;
		if (stall_cycle % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: res_ready <= 1'b1;
			1: res_ready <= ($urandom_range(0, 3) != 0);
			2: res_ready <= ($urandom_range(0, 9) < 3);
			default: res_ready <= (stall_cycle % 5 != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && rx_ready) || (res_valid && res_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Present one byte and hold it until taken; insert gaps between bursts.
	task automatic feed_byte(input logic [7:0] b, input bit counted);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 24);
			@(negedge clk) rx_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!rx_ready);
		burst_left--;
		if (counted)
			framed_items++;
	endtask

	task automatic hold_until_drained();
		@(negedge clk) rx_valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
	endtask

	// Random byte that neither opens anything nor matches the given closer.
	function automatic logic [7:0] pick_payload(input logic [7:0] closer);
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == CMD_OPEN || b == TUNE_OPEN || b == FWD_START || b == closer);
		return b;
	endfunction

	task automatic send_frame();
		logic       tune;
		logic [7:0] closer;
		int         len;
		tune   = 1'($urandom_range(0, 1));
		closer = tune ? TUNE_CLOSE : CMD_CLOSE;
		len    = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 72) : $urandom_range(0, 10);
		feed_byte(tune ? TUNE_OPEN : CMD_OPEN, 1'b1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 29) == 0)
				feed_byte(8'($urandom_range(0, 255)), 1'b1);
			else
				feed_byte(pick_payload(closer), 1'b1);
		end
		if ($urandom_range(0, 9) != 0)
			feed_byte(closer, 1'b1);
	endtask

	task automatic send_forward_run();
		int n;
		n = $urandom_range(1, 12);
		feed_byte(FWD_START, 1'b1);
		repeat (n) feed_byte(pick_payload(FWD_START), 1'b1);
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) feed_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	logic [7:0] directed_bytes[25] = '{
		// closers and plain bytes in idle
		CMD_CLOSE, TUNE_CLOSE, 8'h41,
		// command frame with terminator byte, all-ones and the other closer as data
		CMD_OPEN, 8'h00, 8'hFF, TUNE_CLOSE, 8'h80, CMD_CLOSE,
		// tuning frame carrying a command closer
		TUNE_OPEN, CMD_CLOSE, 8'h7F, TUNE_CLOSE,
		// forward mode passes closers on
		FWD_START, 8'h01, CMD_CLOSE, TUNE_CLOSE, 8'hFE,
		// start bytes abandon whatever is open, then an empty frame
		CMD_OPEN, 8'h11, TUNE_OPEN, 8'h22, FWD_START, CMD_OPEN, CMD_CLOSE
	};

	initial begin
		int pick;
		@(posedge arst_n);
		foreach (directed_bytes[i])
			feed_byte(directed_bytes[i], 1'b1);
		hold_until_drained();
		framed_items = 0;
		while (framed_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				hold_until_drained();
			else if (pick < 66)
				send_frame();
			else if (pick < 82)
				send_forward_run();
			else
				send_noise();
		end
		hold_until_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> filelist.f
rtl/dfr_pkg.sv
rtl/dfr_parser.sv
rtl/dfr_out_stage.sv
rtl/delimited_frame_receiver_top.sv
rtl/dfr_checker.sv
tb/frame_event_checker.sv
tb/tb_top.sv
